[hw/rtl/mtt_pkg.sv]
package mtt_pkg;

  // Width of the span fields carried on the token channel.
  localparam int unsigned SpanBits = 32;

  // One byte can complete at most this many tokens.
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountBits  = $clog2(MaxResults + 1);
  localparam int unsigned IdxBits    = $clog2(MaxResults);

  // Characters that steer the lexer.
  localparam logic [7:0] CharOpenBrace  = 8'h7B;
  localparam logic [7:0] CharCloseBrace = 8'h7D;
  localparam logic [7:0] CharOpenParen  = 8'h28;
  localparam logic [7:0] CharCloseParen = 8'h29;
  localparam logic [7:0] CharQuote      = 8'h22;
  localparam logic [7:0] CharBackslash  = 8'h5C;
  localparam logic [7:0] CharSlash      = 8'h2F;
  localparam logic [7:0] CharStar       = 8'h2A;
  localparam logic [7:0] CharNewline    = 8'h0A;
  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharTab        = 8'h09;
  localparam logic [7:0] CharReturn     = 8'h0D;

  typedef enum logic [2:0] {
    KindOpenBrace  = 3'd0,
    KindCloseBrace = 3'd1,
    KindOpenParen  = 3'd2,
    KindCloseParen = 3'd3,
    KindString     = 3'd4,
    KindAtom       = 3'd5,
    KindEnd        = 3'd6
  } kind_e;

  typedef logic [SpanBits-1:0]  span_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [IdxBits-1:0]   idx_t;

  typedef struct packed {
    kind_e kind;
    span_t start;
    span_t stop;
    logic  open_str;
  } tok_t;

  // All tokens completed by one byte, in order.
  typedef struct packed {
    tok_t [MaxResults-1:0] tok;
    count_t                count;
  } burst_t;

  function automatic tok_t make_tok(kind_e kind, span_t start, span_t stop, logic open_str);
    tok_t t;
    t.kind     = kind;
    t.start    = start;
    t.stop     = stop;
    t.open_str = open_str;
    return t;
  endfunction

endpackage

[hw/rtl/mtt_in_if.sv]
interface mtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

[hw/rtl/mtt_out_if.sv]
interface mtt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [31:0] span_start;
  logic [31:0] span_stop;
  logic        open_string;
  logic        run_end;

  modport source (
    output valid, output token_kind, output span_start, output span_stop,
    output open_string, output run_end, input ready
  );
  modport sink (
    input valid, input token_kind, input span_start, input span_stop,
    input open_string, input run_end, output ready
  );
endinterface

[hw/rtl/mtt_lexer.sv]
module mtt_lexer #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic [7:0]      text_byte_i,
  input  logic            final_byte_i,
  output mtt_pkg::burst_t burst_o
);

  typedef enum logic [2:0] {
    ModeIdle   = 3'd0,
    ModeAtom   = 3'd1,
    ModeString = 3'd2,
    ModeLine   = 3'd3,
    ModeBlock  = 3'd4
  } mode_e;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  mode_e   mode_q, mode_d;
  logic    slash_q, slash_d;
  logic    esc_q, esc_d;
  logic    star_q, star_d;
  offset_t tok_begin_q, tok_begin_d;
  offset_t offset_q, offset_d;

  offset_t pos, pos_next, pos_prev;
  logic    is_space, is_bracket, is_quote, is_slash, is_star, is_bslash, is_newline;
  logic    run_atom, run_idle;
  mtt_pkg::kind_e  bracket;
  mtt_pkg::burst_t burst;

  assign pos      = offset_q;
  assign pos_next = offset_q + offset_t'(1);
  assign pos_prev = offset_q - offset_t'(1);

  // Byte classes.
  assign is_space   = (text_byte_i == mtt_pkg::CharSpace) ||
                      (text_byte_i >= mtt_pkg::CharTab && text_byte_i <= mtt_pkg::CharReturn);
  assign is_quote   = (text_byte_i == mtt_pkg::CharQuote);
  assign is_slash   = (text_byte_i == mtt_pkg::CharSlash);
  assign is_star    = (text_byte_i == mtt_pkg::CharStar);
  assign is_bslash  = (text_byte_i == mtt_pkg::CharBackslash);
  assign is_newline = (text_byte_i == mtt_pkg::CharNewline);

  always_comb begin
    is_bracket = 1'b1;
    bracket    = mtt_pkg::KindOpenBrace;
    case (text_byte_i)
      mtt_pkg::CharOpenBrace:  bracket = mtt_pkg::KindOpenBrace;
      mtt_pkg::CharCloseBrace: bracket = mtt_pkg::KindCloseBrace;
      mtt_pkg::CharOpenParen:  bracket = mtt_pkg::KindOpenParen;
      mtt_pkg::CharCloseParen: bracket = mtt_pkg::KindCloseParen;
      default:                 is_bracket = 1'b0;
    endcase
  end

  // Next lexer state and the tokens completed by the transferred byte.
  always_comb begin
    mode_d      = mode_q;
    slash_d     = slash_q;
    esc_d       = esc_q;
    star_d      = star_q;
    tok_begin_d = tok_begin_q;
    offset_d    = offset_q;
    run_atom    = 1'b0;
    run_idle    = 1'b0;
    burst       = '0;

    if (in_fire_i) begin
      case (mode_q)
        ModeAtom: begin
          if (slash_q && (is_slash || is_star)) begin
            // A comment starts: the atom ends before the slash.
            slash_d = 1'b0;
            burst.tok[mtt_pkg::idx_t'(burst.count)] = mtt_pkg::make_tok(mtt_pkg::KindAtom,
                mtt_pkg::SpanBits'(tok_begin_q), mtt_pkg::SpanBits'(pos_prev), 1'b0);
            burst.count = burst.count + mtt_pkg::count_t'(1);
            mode_d = is_slash ? ModeLine : ModeBlock;
            star_d = 1'b0;
          end else begin
            slash_d  = 1'b0;
            run_atom = 1'b1;
          end
        end
        ModeString: begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (is_bslash) begin
            esc_d = 1'b1;
          end else if (is_quote) begin
            burst.tok[mtt_pkg::idx_t'(burst.count)] = mtt_pkg::make_tok(mtt_pkg::KindString,
                mtt_pkg::SpanBits'(tok_begin_q), mtt_pkg::SpanBits'(pos_next), 1'b0);
            burst.count = burst.count + mtt_pkg::count_t'(1);
            mode_d = ModeIdle;
          end
        end
        ModeLine: begin
          if (is_newline) begin
            mode_d = ModeIdle;
          end
        end
        ModeBlock: begin
          if (star_q && is_slash) begin
            star_d = 1'b0;
            mode_d = ModeIdle;
          end else if (final_byte_i) begin
            // Unterminated comment: its last byte is lexed between tokens.
            star_d   = 1'b0;
            mode_d   = ModeIdle;
            run_idle = 1'b1;
          end else begin
            star_d = is_star;
          end
        end
        default: begin
          mode_d = ModeIdle;
          if (slash_q) begin
            slash_d = 1'b0;
            if (is_slash) begin
              mode_d = ModeLine;
            end else if (is_star) begin
              mode_d = ModeBlock;
              star_d = 1'b0;
            end else begin
              // The pending slash opens an atom.
              mode_d   = ModeAtom;
              run_atom = 1'b1;
            end
          end else begin
            run_idle = 1'b1;
          end
        end
      endcase

      // A byte that arrives inside an atom.
      if (run_atom) begin
        if (is_space || is_bracket || is_quote) begin
          burst.tok[mtt_pkg::idx_t'(burst.count)] = mtt_pkg::make_tok(mtt_pkg::KindAtom,
              mtt_pkg::SpanBits'(tok_begin_q), mtt_pkg::SpanBits'(pos), 1'b0);
          burst.count = burst.count + mtt_pkg::count_t'(1);
          mode_d = ModeIdle;
        end
        if (is_bracket) begin
          burst.tok[mtt_pkg::idx_t'(burst.count)] = mtt_pkg::make_tok(bracket,
              mtt_pkg::SpanBits'(pos), mtt_pkg::SpanBits'(pos_next), 1'b0);
          burst.count = burst.count + mtt_pkg::count_t'(1);
        end else if (is_quote) begin
          mode_d      = ModeString;
          tok_begin_d = pos;
          esc_d       = 1'b0;
        end else if (is_slash && !final_byte_i) begin
          slash_d = 1'b1;
        end
      end

      // A byte that arrives between tokens.
      if (run_idle && !is_space) begin
        if (is_bracket) begin
          burst.tok[mtt_pkg::idx_t'(burst.count)] = mtt_pkg::make_tok(bracket,
              mtt_pkg::SpanBits'(pos), mtt_pkg::SpanBits'(pos_next), 1'b0);
          burst.count = burst.count + mtt_pkg::count_t'(1);
        end else if (is_quote) begin
          mode_d      = ModeString;
          tok_begin_d = pos;
          esc_d       = 1'b0;
        end else if (is_slash && !final_byte_i) begin
          slash_d     = 1'b1;
          tok_begin_d = pos;
        end else begin
          mode_d      = ModeAtom;
          tok_begin_d = pos;
        end
      end

      // The last byte closes any open token, adds the end token and restarts the text.
      if (final_byte_i) begin
        if (mode_d == ModeString) begin
          burst.tok[mtt_pkg::idx_t'(burst.count)] = mtt_pkg::make_tok(mtt_pkg::KindString,
              mtt_pkg::SpanBits'(tok_begin_d), mtt_pkg::SpanBits'(pos_next), 1'b1);
          burst.count = burst.count + mtt_pkg::count_t'(1);
        end else if (mode_d == ModeAtom) begin
          burst.tok[mtt_pkg::idx_t'(burst.count)] = mtt_pkg::make_tok(mtt_pkg::KindAtom,
              mtt_pkg::SpanBits'(tok_begin_d), mtt_pkg::SpanBits'(pos_next), 1'b0);
          burst.count = burst.count + mtt_pkg::count_t'(1);
        end
        burst.tok[mtt_pkg::idx_t'(burst.count)] = mtt_pkg::make_tok(mtt_pkg::KindEnd,
            mtt_pkg::SpanBits'(pos_next), mtt_pkg::SpanBits'(pos_next), 1'b0);
        burst.count = burst.count + mtt_pkg::count_t'(1);
        mode_d      = ModeIdle;
        slash_d     = 1'b0;
        esc_d       = 1'b0;
        star_d      = 1'b0;
        tok_begin_d = '0;
        offset_d    = '0;
      end else begin
        offset_d = pos_next;
      end
    end
  end

  assign burst_o = burst;

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      slash_q     <= 1'b0;
      esc_q       <= 1'b0;
      star_q      <= 1'b0;
      tok_begin_q <= '0;
      offset_q    <= '0;
    end else begin
      mode_q      <= mode_d;
      slash_q     <= slash_d;
      esc_q       <= esc_d;
      star_q      <= star_d;
      tok_begin_q <= tok_begin_d;
      offset_q    <= offset_d;
    end
  end

  // The last byte of a text leaves the lexer as after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && final_byte_i |=> mode_q == ModeIdle && !slash_q && offset_q == '0)
    else $error("lexer state not cleared after the last byte");

  // An escape can only be pending inside a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> mode_q == ModeString)
    else $error("escape pending outside a string");

  // The star flag belongs to block comments only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    star_q |-> mode_q == ModeBlock)
    else $error("star flag set outside a block comment");

endmodule

[hw/rtl/map_text_tokenizer.sv]
// Streaming lexer for map text.
// The text channel (text_i) transfers one byte per cycle together with a flag
// that marks the last byte of a text. The token channel (token_o) transfers one
// token per cycle: its kind, its byte-offset span, a flag for a string cut off
// by the end of the text, and run_end on the last token that a byte produced.
// A byte is lexed in the cycle of its transfer; the tokens it completes are
// offered from the next cycle on.
// Throughput is one byte per cycle while each byte completes at most one token
// and the receiver is ready. A byte that completes several tokens (at most three,
// e.g. an atom, a bracket and the end token) holds off the text channel until its
// last token transfers, as the token register drains one token per ready cycle.
// The text channel is ready whenever the token register is empty or its last
// token transfers in that cycle. A stalled receiver therefore stops input after
// at most one pending byte.
// Reset clears the lexer state and the byte offset and leaves the token channel
// empty. After the end token the next byte starts a new text at offset zero.
module map_text_tokenizer #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtt_in_if.sink    text_i,
  mtt_out_if.source token_o
);

  mtt_pkg::burst_t lex_burst;
  mtt_pkg::tok_t [mtt_pkg::MaxResults-1:0] toks_q, toks_d;
  mtt_pkg::count_t count_q, count_d;
  mtt_pkg::idx_t   idx_q, idx_d;
  mtt_pkg::tok_t   cur;
  logic last, in_ready, in_fire, out_fire;

  // Ready follows the drain of the token register.
  assign last     = (mtt_pkg::count_t'(idx_q) + mtt_pkg::count_t'(1)) == count_q;
  assign in_ready = (count_q == '0) || (token_o.ready && last);
  assign in_fire  = text_i.valid && in_ready;
  assign out_fire = token_o.valid && token_o.ready;

  assign text_i.ready = in_ready;

  mtt_lexer #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .text_byte_i  (text_i.text_byte),
    .final_byte_i (text_i.final_byte),
    .burst_o      (lex_burst)
  );

  // Token register: loads a byte's tokens and hands them out one per transfer.
  always_comb begin
    toks_d  = toks_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (out_fire) begin
      if (last) begin
        count_d = '0;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + mtt_pkg::idx_t'(1);
      end
    end
    if (in_fire && lex_burst.count != '0) begin
      toks_d  = lex_burst.tok;
      count_d = lex_burst.count;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    toks_q <= toks_d;
  end

  // Present the current token.
  assign cur                 = toks_q[idx_q];
  assign token_o.valid       = (count_q != '0);
  assign token_o.token_kind  = cur.kind;
  assign token_o.span_start  = cur.start;
  assign token_o.span_stop   = cur.stop;
  assign token_o.open_string = cur.open_str;
  assign token_o.run_end     = last;

  // The last byte of a text always yields an end token as its final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_i.valid && text_i.ready && text_i.final_byte |=>
      token_o.valid &&
      toks_q[mtt_pkg::idx_t'(count_q - mtt_pkg::count_t'(1))].kind == mtt_pkg::KindEnd)
    else $error("last byte did not produce an end token");

  // Only string tokens can be flagged as unterminated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_o.valid && token_o.open_string |-> token_o.token_kind == mtt_pkg::KindString)
    else $error("open string flag on a token that is not a string");

  // A byte never completes more tokens than the register holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < mtt_pkg::count_t'(mtt_pkg::MaxResults) && idx_q < count_q || count_q == '0)
    else $error("token register count out of range");

endmodule
